FILE: design/free_list_allocator_macros.svh
// Assertion macros for the free list allocator sequencer.
// Depends on nothing; included by files that carry assertions.
`ifndef FREE_LIST_ALLOCATOR_MACROS_SVH
`define FREE_LIST_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FLA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define FLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/fla_pkg.sv
// Package for the free list allocator: table geometry, command and status codes,
// and the request and result transaction structs. No dependencies.
`timescale 1ns / 1ps
package fla_pkg;
	localparam int TableDepth = 4096;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = 13;
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_LOST = 2'd2;

	typedef struct packed {
		logic command;
		logic [31:0] region_address;
		logic [31:0] region_size;
	} req_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [1:0] status;
		logic [31:0] free_total;
		logic [CntW-1:0] entry_count;
		logic [CntW-1:0] peak_entry_count;
		logic [31:0] lost_count;
		logic [31:0] lost_bytes;
	} rsp_t;

	// One table entry: region start and length.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
	} entry_t;

	// Memory port request from the sequencer.
	typedef struct packed {
		logic rd_en;
		logic [IdxW-1:0] rd_addr;
		logic wr_en;
		logic [IdxW-1:0] wr_addr;
		entry_t wr_data;
	} mem_req_t;
endpackage

FILE: design/fla_table_ram.sv
// Region table memory: one write port and one registered read port.
// Depends on fla_pkg.
`timescale 1ns / 1ps
module fla_table_ram (
	input logic clk,
	input fla_pkg::mem_req_t req,
	output fla_pkg::entry_t rd_data
);
	import fla_pkg::*;
	entry_t mem [TableDepth];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule

FILE: design/fla_seq.sv
// Sequencer for the free list allocator: walks the sorted table through the
// memory port, shifts entries, and keeps the running counters. Depends on fla_pkg and the macros header.
`timescale 1ns / 1ps
`include "free_list_allocator_macros.svh"
module fla_seq (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input fla_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output fla_pkg::rsp_t rsp,
	output fla_pkg::mem_req_t mem,
	input fla_pkg::entry_t rd_data
);
	import fla_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ACHK, S_FCHK, S_FNEXT,
		S_RMWR, S_INSRD, S_INSWR, S_DONE
	} state_t;

	localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

	state_t state_q;
	req_t req_q;
	logic [CntW-1:0] held_q, peak_q, pos_q;
	logic [31:0] free_q, lost_n_q, lost_b_q;
	entry_t prev_q;
	logic have_prev_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [31:0] gaddr_q;
	logic [1:0] stat_q;

	logic [31:0] addr_sz;
	logic prev_adj;
	logic next_adj;
	assign addr_sz = req_q.region_address + req_q.region_size;
	assign prev_adj = have_prev_q && (prev_q.start + prev_q.len == req_q.region_address);
	assign next_adj = (rd_data.start == addr_sz);

	// The result register parts the two sides: a new transaction may start while
	// the previous result still waits for the receiver.
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		mem = '0;
		case (state_q)
			S_IDLE: begin
				mem.rd_addr = '0;
				mem.rd_en = req_valid && !req_stall;
			end
			S_ACHK: begin
				if (rd_data.len >= req_q.region_size) begin
					mem.wr_en = (rd_data.len != req_q.region_size);
					mem.wr_addr = pos_q[IdxW-1:0];
					mem.wr_data.start = rd_data.start + req_q.region_size;
					mem.wr_data.len = rd_data.len - req_q.region_size;
					mem.rd_en = 1'b1;
					mem.rd_addr = IdxW'(pos_q + 1'b1);
				end else begin
					mem.rd_en = 1'b1;
					mem.rd_addr = IdxW'(pos_q + 1'b1);
				end
			end
			S_FCHK: begin
				if (rd_data.start <= req_q.region_address) begin
					mem.rd_en = 1'b1;
					mem.rd_addr = IdxW'(pos_q + 1'b1);
				end else if (prev_adj) begin
					mem.wr_en = 1'b1;
					mem.wr_addr = IdxW'(pos_q - 1'b1);
					mem.wr_data.start = prev_q.start;
					mem.wr_data.len = prev_q.len + req_q.region_size +
						(next_adj ? rd_data.len : 32'd0);
					mem.rd_en = next_adj;
					mem.rd_addr = IdxW'(pos_q + 1'b1);
				end else if (next_adj) begin
					mem.wr_en = 1'b1;
					mem.wr_addr = pos_q[IdxW-1:0];
					mem.wr_data.start = req_q.region_address;
					mem.wr_data.len = rd_data.len + req_q.region_size;
				end else if (held_q != DepthCnt) begin
					mem.rd_en = 1'b1;
					mem.rd_addr = IdxW'(held_q - 1'b1);
				end
			end
			S_FNEXT: begin
				// End of table reached without a following entry.
				if (prev_adj) begin
					mem.wr_en = 1'b1;
					mem.wr_addr = IdxW'(pos_q - 1'b1);
					mem.wr_data.start = prev_q.start;
					mem.wr_data.len = prev_q.len + req_q.region_size;
				end else if (held_q != DepthCnt) begin
					mem.wr_en = 1'b1;
					mem.wr_addr = pos_q[IdxW-1:0];
					mem.wr_data.start = req_q.region_address;
					mem.wr_data.len = req_q.region_size;
				end
			end
			S_RMWR: begin
				mem.wr_en = 1'b1;
				mem.wr_addr = IdxW'(pos_q - 1'b1);
				mem.wr_data = rd_data;
				mem.rd_en = 1'b1;
				mem.rd_addr = IdxW'(pos_q + 1'b1);
			end
			S_INSWR: begin
				// pos_q holds the source index of the entry moving up one place.
				mem.wr_en = 1'b1;
				mem.wr_addr = IdxW'(pos_q + 1'b1);
				mem.wr_data = rd_data;
				mem.rd_en = 1'b1;
				mem.rd_addr = IdxW'(pos_q - 1'b1);
			end
			S_INSRD: begin
				mem.wr_en = 1'b1;
				mem.wr_addr = prev_q.start[IdxW-1:0];
				mem.wr_data.start = req_q.region_address;
				mem.wr_data.len = req_q.region_size;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q <= '0;
			peak_q <= '0;
			free_q <= '0;
			lost_n_q <= '0;
			lost_b_q <= '0;
			rsp_valid_q <= 1'b0;
			have_prev_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && !req_stall) begin
						req_q <= req;
						pos_q <= '0;
						have_prev_q <= 1'b0;
						gaddr_q <= '0;
						stat_q <= ST_DONE;
						if (req.command == CMD_ALLOC) begin
							state_q <= (held_q == '0) ? S_DONE : S_ACHK;
							if (held_q == '0) stat_q <= ST_NO_FIT;
						end else begin
							state_q <= (held_q == '0) ? S_FNEXT : S_FCHK;
						end
					end
				end
				S_ACHK: begin
					if (rd_data.len >= req_q.region_size) begin
						gaddr_q <= rd_data.start;
						free_q <= free_q - req_q.region_size;
						if (rd_data.len == req_q.region_size) begin
							held_q <= held_q - 1'b1;
							pos_q <= pos_q + 1'b1;
							state_q <= (pos_q + 1'b1 < held_q) ? S_RMWR : S_DONE;
						end else begin
							state_q <= S_DONE;
						end
					end else if (pos_q + 1'b1 < held_q) begin
						pos_q <= pos_q + 1'b1;
					end else begin
						stat_q <= ST_NO_FIT;
						state_q <= S_DONE;
					end
				end
				S_FCHK: begin
					if (rd_data.start <= req_q.region_address) begin
						prev_q <= rd_data;
						have_prev_q <= 1'b1;
						pos_q <= pos_q + 1'b1;
						if (pos_q + 1'b1 >= held_q) state_q <= S_FNEXT;
					end else if (prev_adj) begin
						free_q <= free_q + req_q.region_size;
						if (next_adj) begin
							held_q <= held_q - 1'b1;
							pos_q <= pos_q + 1'b1;
							state_q <= (pos_q + 1'b1 < held_q) ? S_RMWR : S_DONE;
						end else begin
							state_q <= S_DONE;
						end
					end else if (next_adj) begin
						free_q <= free_q + req_q.region_size;
						state_q <= S_DONE;
					end else if (held_q != DepthCnt) begin
						// Shift entries pos..held-1 up by one, top first.
						prev_q.start <= 32'(pos_q);
						pos_q <= held_q - 1'b1;
						held_q <= held_q + 1'b1;
						if (held_q + 1'b1 > peak_q) peak_q <= held_q + 1'b1;
						free_q <= free_q + req_q.region_size;
						state_q <= S_INSWR;
					end else begin
						lost_n_q <= lost_n_q + 1'b1;
						lost_b_q <= lost_b_q + req_q.region_size;
						stat_q <= ST_LOST;
						state_q <= S_DONE;
					end
				end
				S_FNEXT: begin
					if (prev_adj) begin
						free_q <= free_q + req_q.region_size;
					end else if (held_q != DepthCnt) begin
						held_q <= held_q + 1'b1;
						if (held_q + 1'b1 > peak_q) peak_q <= held_q + 1'b1;
						free_q <= free_q + req_q.region_size;
					end else begin
						lost_n_q <= lost_n_q + 1'b1;
						lost_b_q <= lost_b_q + req_q.region_size;
						stat_q <= ST_LOST;
					end
					state_q <= S_DONE;
				end
				S_RMWR: begin
					// pos_q is the source index; held_q is already decremented.
					pos_q <= pos_q + 1'b1;
					if (pos_q + 1'b1 > held_q) state_q <= S_DONE;
				end
				S_INSWR: begin
					if (pos_q == prev_q.start[CntW-1:0]) begin
						state_q <= S_INSRD;
					end else begin
						pos_q <= pos_q - 1'b1;
					end
				end
				S_INSRD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q) begin
						rsp_q.granted_address <= gaddr_q;
						rsp_q.status <= stat_q;
						rsp_q.free_total <= free_q;
						rsp_q.entry_count <= held_q;
						rsp_q.peak_entry_count <= peak_q;
						rsp_q.lost_count <= lost_n_q;
						rsp_q.lost_bytes <= lost_b_q;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FLA_ASSERT_IMP(a_held_le_depth, clk, arst_n, 1'b1, held_q <= DepthCnt, "entry count above depth")
	`FLA_ASSERT_IMP(a_peak_ge_held, clk, arst_n, 1'b1, peak_q >= held_q, "peak below entry count")
	`FLA_ASSERT_NEXT(a_rsp_from_done, clk, arst_n, !rsp_valid_q && !(state_q == S_DONE), !rsp_valid_q, "result without completion")
endmodule

FILE: design/free_list_allocator.sv
// Free list allocator: first-fit allocation with coalescing frees over a sorted
// region table of TableDepth entries held in a synchronous RAM with a registered read.
// Per request the sequencer reads entries in order up to the match or insertion
// point, then moves entries one place where needed, before the result registers.
// A new request is accepted the cycle after the result registers, even while it waits.
// Reset clears the counters at once; entries past the entry count may be read, but their data is never used.
`timescale 1ns / 1ps
module free_list_allocator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input fla_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output fla_pkg::rsp_t out_data
);
	import fla_pkg::*;
	mem_req_t mem;
	entry_t rd_data;

	fla_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.req_valid(in_valid), .req_stall(in_stall), .req(in_data),
		.rsp_valid(out_valid), .rsp_stall(out_stall), .rsp(out_data),
		.mem(mem), .rd_data(rd_data)
	);

	fla_table_ram u_ram (.clk(clk), .req(mem), .rd_data(rd_data));
endmodule
